// File: rtl/core/oblivious_tree_leaf_mobius_transform_macros.svh
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: assertion macros
// Concurrent checks that fold away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef OBLIVIOUS_TREE_LEAF_MOBIUS_TRANSFORM_MACROS_SVH
`define OBLIVIOUS_TREE_LEAF_MOBIUS_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS

`define OTLMT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define OTLMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define OTLMT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define OTLMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/otlmt_pkg.sv
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: package
// Shared widths, reset values and the leaf request queue entry.
// ----------------------------------------------------------------------------
package otlmt_pkg;

    localparam int LEAF_W         = 32;
    localparam int IDX_W          = 6;
    localparam int COEF_W         = 38;
    localparam int DEPTH_W        = 3;
    localparam int MAX_DEPTH_DEF  = 6;

    localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = 3'd6;

    typedef struct packed {
        logic signed [LEAF_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic                     last;
    } t_leaf_ent;

endpackage

// File: rtl/core/otlmt_front.sv
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: front end
// Accepts leaf requests, tags each with its slot index and last-leaf flag.
// ----------------------------------------------------------------------------
module otlmt_front #(
    parameter int MAX_DEPTH = otlmt_pkg::MAX_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [otlmt_pkg::DEPTH_W-1:0]       i_eff_depth,
    input  logic                                i_cfg_we,
    input  logic                                i_leaf_valid,
    input  logic signed [otlmt_pkg::LEAF_W-1:0] i_leaf_value,
    output logic                                o_leaf_ready,
    input  logic                                i_q_full,
    output logic                                o_push,
    output otlmt_pkg::t_leaf_ent                o_ent
);

    localparam int AW = MAX_DEPTH;
    localparam int IW = otlmt_pkg::IDX_W;

    logic [AW:0] r_cnt;
    logic [AW:0] n_cnt;
    logic [AW:0] w_count;
    logic [AW:0] w_cnt_inc;
    logic        w_last;

    assign w_count      = (AW+1)'(1) << i_eff_depth;
    assign w_cnt_inc    = r_cnt + (AW+1)'(1);
    assign w_last       = (w_cnt_inc == w_count);
    assign o_leaf_ready = !i_q_full;
    assign o_push       = i_leaf_valid && !i_q_full;

    assign o_ent.value = i_leaf_value;
    assign o_ent.index = IW'(r_cnt[AW-1:0]);
    assign o_ent.last  = w_last;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cfg_we) begin
            n_cnt = '0;
        end else if (o_push) begin
            n_cnt = w_last ? '0 : w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/core/otlmt_queue.sv
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: request queue
// Two-entry FIFO between the front end and the transform engine.
// ----------------------------------------------------------------------------
module otlmt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  otlmt_pkg::t_leaf_ent i_ent,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output otlmt_pkg::t_leaf_ent o_ent
);

    otlmt_pkg::t_leaf_ent r_slot [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_ent   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/otlmt_back.sv
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: transform engine
// Loads leaves into the value store, runs the subtract butterfly passes
// one pair per cycle and streams coefficients out through a read
// register and an output register.
module otlmt_back #(
    parameter int MAX_DEPTH = otlmt_pkg::MAX_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [otlmt_pkg::DEPTH_W-1:0]       i_eff_depth,
    input  logic                                i_q_valid,
    input  otlmt_pkg::t_leaf_ent                i_ent,
    output logic                                o_pop,
    output logic                                o_coef_valid,
    input  logic                                i_coef_ready,
    output logic [otlmt_pkg::IDX_W-1:0]         o_monomial_index,
    output logic signed [otlmt_pkg::COEF_W-1:0] o_coefficient,
    output logic                                o_last_coefficient
);

    localparam int AW   = MAX_DEPTH;
    localparam int NENT = 1 << AW;
    localparam int CW   = otlmt_pkg::LEAF_W + AW;
    localparam int IW   = otlmt_pkg::IDX_W;
    localparam int OW   = otlmt_pkg::COEF_W;
    localparam int DW   = otlmt_pkg::DEPTH_W;

    typedef enum logic [1:0] {
        S_LOAD,
        S_XFORM,
        S_DRAIN,
        S_EMIT
    } t_state;

    logic signed [CW-1:0] r_mem [NENT];
    logic signed [CW-1:0] r_rd_a;
    logic signed [CW-1:0] r_rd_b;

    t_state               r_state;
    logic [DW-1:0]        r_pass;
    logic [AW-1:0]        r_step;
    logic [AW-1:0]        r_k;
    logic                 r_iss_done;
    logic                 r_p1_vld;
    logic [AW-1:0]        r_p1_addr;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_rd_last;
    logic                 r_out_vld;
    logic [AW-1:0]        r_out_idx;
    logic signed [CW-1:0] r_out_coef;
    logic                 r_out_last;

    logic [AW:0]          w_count;
    logic [AW-1:0]        w_cnt_m1;
    logic [AW-1:0]        w_half_m1;
    logic [DW-1:0]        w_depth_m1;
    logic [AW-1:0]        w_bit;
    logic [AW-1:0]        w_mask;
    logic [AW-1:0]        w_lo;
    logic [AW-1:0]        w_hi;
    logic signed [CW-1:0] w_diff;
    logic                 w_out_free;
    logic                 w_issue;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic signed [CW-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr_a;

    assign w_count    = (AW+1)'(1) << i_eff_depth;
    assign w_cnt_m1   = AW'(w_count - (AW+1)'(1));
    assign w_half_m1  = w_count[AW:1] - AW'(1);
    assign w_depth_m1 = i_eff_depth - DW'(1);

    assign w_bit  = AW'(1) << r_pass;
    assign w_mask = w_bit - AW'(1);
    assign w_lo   = ((r_step & ~w_mask) << 1) | (r_step & w_mask);
    assign w_hi   = w_lo | w_bit;
    assign w_diff = r_rd_a - r_rd_b;

    assign o_pop      = (r_state == S_LOAD) && i_q_valid;
    assign w_out_free = !r_out_vld || i_coef_ready;
    assign w_issue    = (r_state == S_EMIT) && !r_iss_done && (!r_rd_vld || w_out_free);

    assign w_we      = o_pop || r_p1_vld;
    assign w_waddr   = r_p1_vld ? r_p1_addr : i_ent.index[AW-1:0];
    assign w_wdata   = r_p1_vld ? w_diff : CW'(i_ent.value);
    assign w_re      = (r_state == S_XFORM) || w_issue;
    assign w_raddr_a = (r_state == S_XFORM) ? w_hi : r_k;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_a <= r_mem[w_raddr_a];
            r_rd_b <= r_mem[w_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_pass     <= '0;
            r_step     <= '0;
            r_k        <= '0;
            r_iss_done <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_p1_vld  <= (r_state == S_XFORM);
            r_p1_addr <= w_hi;

            unique case (r_state)
                S_LOAD: begin
                    if (o_pop && i_ent.last) begin
                        r_pass     <= '0;
                        r_step     <= '0;
                        r_k        <= '0;
                        r_iss_done <= 1'b0;
                        r_state    <= (i_eff_depth == '0) ? S_EMIT : S_XFORM;
                    end
                end
                S_XFORM: begin
                    if (r_step == w_half_m1) begin
                        r_step  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_pass == w_depth_m1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_pass  <= r_pass + DW'(1);
                        r_state <= S_XFORM;
                    end
                end
                S_EMIT: begin
                    if (w_issue) begin
                        if (r_k == w_cnt_m1) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end
                    if (r_iss_done && !r_rd_vld) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (w_issue) begin
                r_rd_vld  <= 1'b1;
                r_rd_idx  <= r_k;
                r_rd_last <= (r_k == w_cnt_m1);
            end else if (w_out_free) begin
                r_rd_vld <= 1'b0;
            end

            if (w_out_free) begin
                r_out_vld <= r_rd_vld;
                if (r_rd_vld) begin
                    r_out_idx  <= r_rd_idx;
                    r_out_coef <= r_rd_a;
                    r_out_last <= r_rd_last;
                end
            end
        end
    end

    assign o_coef_valid       = r_out_vld;
    assign o_monomial_index   = IW'(r_out_idx);
    assign o_coefficient      = OW'(r_out_coef);
    assign o_last_coefficient = r_out_last;

endmodule

// File: rtl/core/oblivious_tree_leaf_mobius_transform.sv
// Operation: a tree of 2^d leaves loads at one leaf per cycle while leaves are queued,
// then takes d subtract passes, then streams 2^d coefficients at one per cycle while
// i_coef_ready is high. The load, transform and emit phases run one after another, so
// a new tree is not loaded until the previous tree has been read out of the store.
// Reset: depth register returns to 6, leaf count and queue clear; store is not cleared.
// ----------------------------------------------------------------------------
// Oblivious tree leaf Moebius transform: top level
// Depth register, front end, request queue and transform engine.
// ----------------------------------------------------------------------------
`include "oblivious_tree_leaf_mobius_transform_macros.svh"

module oblivious_tree_leaf_mobius_transform #(
    parameter int MAX_DEPTH = otlmt_pkg::MAX_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [otlmt_pkg::DEPTH_W-1:0]       i_cfg_wdata,
    input  logic                                i_leaf_valid,
    output logic                                o_leaf_ready,
    input  logic signed [otlmt_pkg::LEAF_W-1:0] i_leaf_value,
    output logic                                o_coef_valid,
    input  logic                                i_coef_ready,
    output logic [otlmt_pkg::IDX_W-1:0]         o_monomial_index,
    output logic signed [otlmt_pkg::COEF_W-1:0] o_coefficient,
    output logic                                o_last_coefficient
);

    localparam int DW = otlmt_pkg::DEPTH_W;
    localparam int IW = otlmt_pkg::IDX_W;

    logic [DW-1:0]        r_tree_depth;
    logic [DW-1:0]        w_eff_depth;
    logic [IW:0]          w_count;
    logic [IW-1:0]        w_last_idx;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_valid;
    otlmt_pkg::t_leaf_ent w_front_ent;
    otlmt_pkg::t_leaf_ent w_back_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth <= otlmt_pkg::TREE_DEPTH_RST;
        end else if (i_cfg_we) begin
            r_tree_depth <= i_cfg_wdata;
        end
    end

    assign w_eff_depth = (r_tree_depth > DW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : r_tree_depth;
    assign w_count     = (IW+1)'(1) << w_eff_depth;
    assign w_last_idx  = IW'(w_count - (IW+1)'(1));

    otlmt_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff_depth  (w_eff_depth),
        .i_cfg_we     (i_cfg_we),
        .i_leaf_valid (i_leaf_valid),
        .i_leaf_value (i_leaf_value),
        .o_leaf_ready (o_leaf_ready),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_ent        (w_front_ent)
    );

    otlmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_front_ent),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_ent   (w_back_ent)
    );

    otlmt_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_eff_depth        (w_eff_depth),
        .i_q_valid          (w_q_valid),
        .i_ent              (w_back_ent),
        .o_pop              (w_pop),
        .o_coef_valid       (o_coef_valid),
        .i_coef_ready       (i_coef_ready),
        .o_monomial_index   (o_monomial_index),
        .o_coefficient      (o_coefficient),
        .o_last_coefficient (o_last_coefficient)
    );

    `OTLMT_ASSERT_IMPLY(a_last_at_top_index, i_clk, i_rst_n, o_coef_valid && o_last_coefficient, o_monomial_index == w_last_idx)
    `OTLMT_ASSERT_NEXT(a_index_advances, i_clk, i_rst_n, o_coef_valid && i_coef_ready && !o_last_coefficient, !o_coef_valid || (o_monomial_index == $past(o_monomial_index) + IW'(1)))
    `OTLMT_ASSERT_NEXT(a_new_tree_at_zero, i_clk, i_rst_n, o_coef_valid && i_coef_ready && o_last_coefficient, !o_coef_valid || (o_monomial_index == '0))

endmodule
